// ===== src/mplm_pkg.sv =====
// ============================================================================
// mplm_pkg
// Shared widths, register codes, reset values and helpers of the mesh
// packet latency model.
// ============================================================================
package mplm_pkg;

    // defaults of the top level parameters
    localparam int MAX_DIMS_DEF  = 3;
    localparam int NODE_BITS_DEF = 16;

    // field widths
    localparam int LEN_W      = 16;
    localparam int NODE_IN_W  = 16;
    localparam int RADIX_W    = 9;
    localparam int DIMS_W     = 2;
    localparam int FB_W       = 10;
    localparam int Q16_W      = 32;
    localparam int Q16_FRAC   = 16;
    localparam int FLIT_W     = 19;
    localparam int HOPD_W     = 10;
    localparam int CYC_W      = 32;
    localparam int FH_OUT_W   = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // bit-steps of a long division done in one pipeline stage
    localparam int DIV_STEPS = 4;

    // largest ring distance in one dimension: radix - 1 with radix < 2^RADIX_W
    localparam int MAX_DIGIT_DIST = (1 << RADIX_W) - 2;
    localparam int HOPD_MAX       = (1 << HOPD_W) - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX     = 3'd0,
        CFG_NUM_DIMS  = 3'd1,
        CFG_FLIT_BITS = 3'd2,
        CFG_HOP_COST  = 3'd3,
        CFG_COEF      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [DIMS_W-1:0]  num_dims;
        logic [FB_W-1:0]    flit_bits;
        logic [Q16_W-1:0]   hop_cost_q16;
        logic [Q16_W-1:0]   contention_coef_q16;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        radix:               9'd4,
        num_dims:            2'd2,
        flit_bits:           10'd32,
        hop_cost_q16:        32'h0001_0000,
        contention_coef_q16: 32'h0000_0000
    };

    // width of the summed hop distance over all dimensions
    function automatic int dist_width(input int max_dims);
        return $clog2(max_dims * MAX_DIGIT_DIST + 1);
    endfunction

endpackage

// ===== src/mplm_if.sv =====
// ============================================================================
// mplm channel interfaces
// Packet input, result output and register write channels, each with
// valid/ready and a source and sink modport.
// ============================================================================
interface mplm_pkt_if;
    import mplm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [LEN_W-1:0]     length_bytes;
    logic [NODE_IN_W-1:0] src_node;
    logic [NODE_IN_W-1:0] dst_node;

    modport source (output valid, length_bytes, src_node, dst_node, input ready);
    modport sink   (input valid, length_bytes, src_node, dst_node, output ready);
endinterface

interface mplm_res_if;
    import mplm_pkg::*;

    logic                valid;
    logic                ready;
    logic [CYC_W-1:0]    latency_cycles;
    logic [CYC_W-1:0]    contention_cycles;
    logic [HOPD_W-1:0]   hop_distance;
    logic [FLIT_W-1:0]   flit_count;
    logic [FH_OUT_W-1:0] flit_hops;

    modport source (output valid, latency_cycles, contention_cycles, hop_distance,
                    flit_count, flit_hops, input ready);
    modport sink   (input valid, latency_cycles, contention_cycles, hop_distance,
                    flit_count, flit_hops, output ready);
endinterface

interface mplm_cfg_if;
    import mplm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/mplm_flit_div.sv =====
// ============================================================================
// mplm_flit_div
// Pipelined restoring divider: flit count = ceil(length_bytes * 8 / flit_bits),
// DIV_STEPS quotient bits per stage. Node numbers ride along.
// ============================================================================
module mplm_flit_div #(
    parameter int NODE_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mplm_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mplm_pkg::LEN_W-1:0]    i_len,
    input  logic [NODE_W-1:0]             i_src,
    input  logic [NODE_W-1:0]             i_dst,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mplm_pkg::FLIT_W-1:0]   o_flits,
    output logic [NODE_W-1:0]             o_src,
    output logic [NODE_W-1:0]             o_dst
);
    import mplm_pkg::*;

    localparam int DVD_W = LEN_W + 3;
    localparam int NS    = (DVD_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int REM_W = FB_W;

    logic [NS:0]        en;
    logic [NS:0]        v_in;
    logic [NS-1:0]      r_vld;
    logic [DVD_W-1:0]   r_x   [NS];
    logic [REM_W-1:0]   r_rem [NS];
    logic [NODE_W-1:0]  r_src [NS];
    logic [NODE_W-1:0]  r_dst [NS];
    logic [DVD_W-1:0]   n_x   [NS];
    logic [REM_W-1:0]   n_rem [NS];
    logic [REM_W-1:0]   divisor;

    // zero width counts as one bit per flit
    assign divisor = (i_cfg.flit_bits == '0) ? REM_W'(1) : i_cfg.flit_bits;

    // a stage takes a new item when empty or when its item moves on
    always_comb begin
        en[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign v_in = {r_vld, i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= v_in[s];
                end
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [DVD_W-1:0]  x_in;
        logic [REM_W-1:0]  rem_in;
        logic [NODE_W-1:0] src_in;
        logic [NODE_W-1:0] dst_in;

        if (s == 0) begin : g_first
            assign x_in   = {i_len, 3'b000};
            assign rem_in = '0;
            assign src_in = i_src;
            assign dst_in = i_dst;
        end else begin : g_next
            assign x_in   = r_x[s-1];
            assign rem_in = r_rem[s-1];
            assign src_in = r_src[s-1];
            assign dst_in = r_dst[s-1];
        end

        always_comb begin
            logic [DVD_W-1:0] x;
            logic [REM_W-1:0] rem;
            logic [REM_W:0]   sh;
            x   = x_in;
            rem = rem_in;
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (s * DIV_STEPS + j < DVD_W) begin
                    sh = {rem, x[DVD_W-1]};
                    if (sh >= {1'b0, divisor}) begin
                        rem = REM_W'(sh - {1'b0, divisor});
                        x   = {x[DVD_W-2:0], 1'b1};
                    end else begin
                        rem = sh[REM_W-1:0];
                        x   = {x[DVD_W-2:0], 1'b0};
                    end
                end
            end
            // round up on a partial last flit
            if (s == NS - 1) begin
                x = x + DVD_W'(rem != '0);
            end
            n_x[s]   = x;
            n_rem[s] = rem;
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_x[s]   <= n_x[s];
                r_rem[s] <= n_rem[s];
                r_src[s] <= src_in;
                r_dst[s] <= dst_in;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_flits = FLIT_W'(r_x[NS-1]);
    assign o_src   = r_src[NS-1];
    assign o_dst   = r_dst[NS-1];

endmodule

// ===== src/mplm_hop_dist.sv =====
// ============================================================================
// mplm_hop_dist
// Splits source and destination node numbers into base-radix digits with a
// pipelined restoring divider and sums the unidirectional ring distance.
// ============================================================================
module mplm_hop_dist #(
    parameter int MAX_DIMS = 3,
    parameter int NODE_W   = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  mplm_pkg::t_cfg                                   i_cfg,
    input  logic                                             i_valid,
    output logic                                             o_ready,
    input  logic [mplm_pkg::FLIT_W-1:0]                      i_flits,
    input  logic [NODE_W-1:0]                                i_src,
    input  logic [NODE_W-1:0]                                i_dst,
    output logic                                             o_valid,
    input  logic                                             i_ready,
    output logic [mplm_pkg::FLIT_W-1:0]                      o_flits,
    output logic [mplm_pkg::dist_width(MAX_DIMS)-1:0]        o_dist
);
    import mplm_pkg::*;

    localparam int DIST_W = dist_width(MAX_DIMS);
    localparam int TSTEPS = MAX_DIMS * NODE_W;
    localparam int NS     = (TSTEPS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int REM_W  = RADIX_W;

    logic [NS:0]          en;
    logic [NS:0]          v_in;
    logic [NS-1:0]        r_vld;
    logic [NODE_W-1:0]    r_sx    [NS];
    logic [NODE_W-1:0]    r_dx    [NS];
    logic [REM_W-1:0]     r_srem  [NS];
    logic [REM_W-1:0]     r_drem  [NS];
    logic [DIST_W-1:0]    r_dist  [NS];
    logic [FLIT_W-1:0]    r_flits [NS];
    logic [NODE_W-1:0]    n_sx    [NS];
    logic [NODE_W-1:0]    n_dx    [NS];
    logic [REM_W-1:0]     n_srem  [NS];
    logic [REM_W-1:0]     n_drem  [NS];
    logic [DIST_W-1:0]    n_dist  [NS];
    logic [MAX_DIMS-1:0]  dim_on;

    function automatic logic [REM_W-1:0] ring_dist(
        input logic [REM_W-1:0] s,
        input logic [REM_W-1:0] d,
        input logic [REM_W-1:0] r
    );
        // wrap to r - (s - d) when the source digit is larger
        return (s > d) ? REM_W'(r - s + d) : REM_W'(d - s);
    endfunction

    // dimensions above MAX_DIMS are dropped, radix below two means no hops
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            dim_on[d] = (i_cfg.radix >= REM_W'(2)) && (32'(i_cfg.num_dims) > 32'(d));
        end
    end

    always_comb begin
        en[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign v_in = {r_vld, i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= v_in[s];
                end
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [NODE_W-1:0] sx_in;
        logic [NODE_W-1:0] dx_in;
        logic [REM_W-1:0]  srem_in;
        logic [REM_W-1:0]  drem_in;
        logic [DIST_W-1:0] dist_in;
        logic [FLIT_W-1:0] flits_in;

        if (s == 0) begin : g_first
            assign sx_in    = i_src;
            assign dx_in    = i_dst;
            assign srem_in  = '0;
            assign drem_in  = '0;
            assign dist_in  = '0;
            assign flits_in = i_flits;
        end else begin : g_next
            assign sx_in    = r_sx[s-1];
            assign dx_in    = r_dx[s-1];
            assign srem_in  = r_srem[s-1];
            assign drem_in  = r_drem[s-1];
            assign dist_in  = r_dist[s-1];
            assign flits_in = r_flits[s-1];
        end

        always_comb begin
            logic [NODE_W-1:0] sx;
            logic [NODE_W-1:0] dx;
            logic [REM_W-1:0]  srem;
            logic [REM_W-1:0]  drem;
            logic [DIST_W-1:0] dist_acc;
            logic [REM_W:0]    ssh;
            logic [REM_W:0]    dsh;
            int                k;
            sx       = sx_in;
            dx       = dx_in;
            srem     = srem_in;
            drem     = drem_in;
            dist_acc = dist_in;
            for (int j = 0; j < DIV_STEPS; j++) begin
                k = s * DIV_STEPS + j;
                if (k < TSTEPS) begin
                    ssh = {srem, sx[NODE_W-1]};
                    dsh = {drem, dx[NODE_W-1]};
                    if (ssh >= {1'b0, i_cfg.radix}) begin
                        srem = REM_W'(ssh - {1'b0, i_cfg.radix});
                        sx   = {sx[NODE_W-2:0], 1'b1};
                    end else begin
                        srem = ssh[REM_W-1:0];
                        sx   = {sx[NODE_W-2:0], 1'b0};
                    end
                    if (dsh >= {1'b0, i_cfg.radix}) begin
                        drem = REM_W'(dsh - {1'b0, i_cfg.radix});
                        dx   = {dx[NODE_W-2:0], 1'b1};
                    end else begin
                        drem = dsh[REM_W-1:0];
                        dx   = {dx[NODE_W-2:0], 1'b0};
                    end
                    // last bit of a dimension: remainders are the digits,
                    // the quotients go on as the next dividends
                    if (k % NODE_W == NODE_W - 1) begin
                        if (dim_on[k / NODE_W]) begin
                            dist_acc = dist_acc + DIST_W'(ring_dist(srem, drem, i_cfg.radix));
                        end
                        srem = '0;
                        drem = '0;
                    end
                end
            end
            n_sx[s]   = sx;
            n_dx[s]   = dx;
            n_srem[s] = srem;
            n_drem[s] = drem;
            n_dist[s] = dist_acc;
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_sx[s]    <= n_sx[s];
                r_dx[s]    <= n_dx[s];
                r_srem[s]  <= n_srem[s];
                r_drem[s]  <= n_drem[s];
                r_dist[s]  <= n_dist[s];
                r_flits[s] <= flits_in;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_flits = r_flits[NS-1];
    assign o_dist  = r_dist[NS-1];

endmodule

// ===== src/mplm_cost.sv =====
// ============================================================================
// mplm_cost
// Six-stage fixed-point datapath: contention and latency in Q16.16 scaled by
// the hop cost, ceiling and floor, saturation, and the flit-hop usage count.
// ============================================================================
module mplm_cost #(
    parameter int MAX_DIMS = 3
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  mplm_pkg::t_cfg                              i_cfg,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic [mplm_pkg::FLIT_W-1:0]                 i_flits,
    input  logic [mplm_pkg::dist_width(MAX_DIMS)-1:0]   i_dist,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [mplm_pkg::CYC_W-1:0]                  o_latency_cycles,
    output logic [mplm_pkg::CYC_W-1:0]                  o_contention_cycles,
    output logic [mplm_pkg::HOPD_W-1:0]                 o_hop_distance,
    output logic [mplm_pkg::FLIT_W-1:0]                 o_flit_count,
    output logic [mplm_pkg::FH_OUT_W-1:0]               o_flit_hops
);
    import mplm_pkg::*;

    localparam int NS      = 6;
    localparam int DIST_W  = dist_width(MAX_DIMS);
    localparam int DF_W    = DIST_W + FLIT_W;
    localparam int SUM_W   = ((DIST_W > FLIT_W) ? DIST_W : FLIT_W) + 1;
    localparam int FH_W    = FLIT_W + SUM_W;
    localparam int CONT_W  = DF_W + Q16_W;
    localparam int INNER_W = CONT_W + 1;
    localparam int PROD_W  = 2 * Q16_W;
    localparam int LH_W    = INNER_W + 1;
    localparam int LR_W    = LH_W + 1;
    localparam int CH_W    = CONT_W + 1;

    logic [NS:0]          en;
    logic [NS:0]          v_in;
    logic [NS-1:0]        r_vld;

    logic [SUM_W-1:0]     n_sum;
    logic [HOPD_W-1:0]    n_hd;
    logic [LR_W-1:0]      n_lat;

    logic [DF_W-1:0]      r1_df;
    logic [SUM_W-1:0]     r1_sum;
    logic [FH_W-1:0]      r1_fh;
    logic [HOPD_W-1:0]    r1_hd;
    logic [FLIT_W-1:0]    r1_fl;

    logic [CONT_W-1:0]    r2_cont;
    logic [SUM_W-1:0]     r2_sum;
    logic [FH_W-1:0]      r2_fh;
    logic [HOPD_W-1:0]    r2_hd;
    logic [FLIT_W-1:0]    r2_fl;

    logic [INNER_W-1:0]   r3_inner;
    logic [CONT_W-1:0]    r3_cont;
    logic [FH_W-1:0]      r3_fh;
    logic [HOPD_W-1:0]    r3_hd;
    logic [FLIT_W-1:0]    r3_fl;

    logic [PROD_W-1:0]    r4_ilo;
    logic [INNER_W-1:0]   r4_ihi;
    logic [PROD_W-1:0]    r4_clo;
    logic [CONT_W-1:0]    r4_chi;
    logic [FH_W-1:0]      r4_fh;
    logic [HOPD_W-1:0]    r4_hd;
    logic [FLIT_W-1:0]    r4_fl;

    logic [LH_W-1:0]      r5_lh;
    logic                 r5_nz;
    logic [CH_W-1:0]      r5_ch;
    logic [FH_W-1:0]      r5_fh;
    logic [HOPD_W-1:0]    r5_hd;
    logic [FLIT_W-1:0]    r5_fl;

    logic [CYC_W-1:0]     r6_lat;
    logic [CYC_W-1:0]     r6_cont;
    logic [FH_W-1:0]      r6_fh;
    logic [HOPD_W-1:0]    r6_hd;
    logic [FLIT_W-1:0]    r6_fl;

    always_comb begin
        en[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign v_in = {r_vld, i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= v_in[s];
                end
            end
        end
    end

    always_comb begin
        n_sum = SUM_W'(i_dist) + SUM_W'(i_flits);
        n_hd  = (32'(i_dist) > 32'(HOPD_MAX)) ? HOPD_W'(HOPD_MAX) : HOPD_W'(i_dist);
        n_lat = LR_W'(r5_lh) + LR_W'(r5_nz);
    end

    always_ff @(posedge i_clk) begin
        // distance times flits, and the usage count
        if (en[0]) begin
            r1_df  <= DF_W'(i_dist) * DF_W'(i_flits);
            r1_sum <= n_sum;
            r1_fh  <= FH_W'(i_flits) * FH_W'(n_sum);
            r1_hd  <= n_hd;
            r1_fl  <= i_flits;
        end
        // contention in Q16.16 before the hop cost
        if (en[1]) begin
            r2_cont <= CONT_W'(r1_df) * CONT_W'(i_cfg.contention_coef_q16);
            r2_sum  <= r1_sum;
            r2_fh   <= r1_fh;
            r2_hd   <= r1_hd;
            r2_fl   <= r1_fl;
        end
        // (dist + flits) in Q16.16 plus contention
        if (en[2]) begin
            r3_inner <= INNER_W'(r2_cont) + (INNER_W'(r2_sum) << Q16_FRAC);
            r3_cont  <= r2_cont;
            r3_fh    <= r2_fh;
            r3_hd    <= r2_hd;
            r3_fl    <= r2_fl;
        end
        // hop cost products split at bit 32
        if (en[3]) begin
            r4_ilo <= PROD_W'(r3_inner[Q16_W-1:0]) * PROD_W'(i_cfg.hop_cost_q16);
            r4_ihi <= INNER_W'(r3_inner[INNER_W-1:Q16_W]) * INNER_W'(i_cfg.hop_cost_q16);
            r4_clo <= PROD_W'(r3_cont[Q16_W-1:0]) * PROD_W'(i_cfg.hop_cost_q16);
            r4_chi <= CONT_W'(r3_cont[CONT_W-1:Q16_W]) * CONT_W'(i_cfg.hop_cost_q16);
            r4_fh  <= r3_fh;
            r4_hd  <= r3_hd;
            r4_fl  <= r3_fl;
        end
        // integer parts; low word decides the ceiling
        if (en[4]) begin
            r5_lh <= LH_W'(r4_ihi) + LH_W'(r4_ilo[PROD_W-1:Q16_W]);
            r5_nz <= |r4_ilo[Q16_W-1:0];
            r5_ch <= CH_W'(r4_chi) + CH_W'(r4_clo[PROD_W-1:Q16_W]);
            r5_fh <= r4_fh;
            r5_hd <= r4_hd;
            r5_fl <= r4_fl;
        end
        // round up and saturate into the output register
        if (en[5]) begin
            r6_lat  <= (|n_lat[LR_W-1:CYC_W]) ? '1 : n_lat[CYC_W-1:0];
            r6_cont <= (|r5_ch[CH_W-1:CYC_W]) ? '1 : r5_ch[CYC_W-1:0];
            r6_fh   <= r5_fh;
            r6_hd   <= r5_hd;
            r6_fl   <= r5_fl;
        end
    end

    assign o_ready             = en[0];
    assign o_valid             = r_vld[NS-1];
    assign o_latency_cycles    = r6_lat;
    assign o_contention_cycles = r6_cont;
    assign o_hop_distance      = r6_hd;
    assign o_flit_count        = r6_fl;
    assign o_flit_hops         = FH_OUT_W'(r6_fh);

endmodule

// ===== src/mesh_packet_latency_model_core.sv =====
// ============================================================================
// mesh_packet_latency_model_core
// Per-packet latency model of a unidirectional k-ary n-cube, one packet in,
// one result out.
// ============================================================================
// i_pkt carries length_bytes, src_node and dst_node; o_res returns latency,
// contention, hop distance, flit count and flit-hops for each packet, in
// order. i_cfg writes the five registers by index (radix, num_dims,
// flit_bits, hop_cost_q16, contention_coef_q16); it is always ready. The user
// must write it only while no packet is in flight; the block does not enforce it.
// Throughput: one packet per cycle while o_res is not stalled. The pipeline
// is made up of the two long dividers (four quotient bits per stage, for the
// flit count and for the node digits) and the six-stage multiply datapath.
// Reset clears every stage valid bit and loads the register reset values.
// When o_res is stalled the result holds in the output register; stages
// behind it keep filling empty slots and i_pkt.ready drops only once the
// whole pipeline is full.
// ============================================================================
module mesh_packet_latency_model_core #(
    parameter int MAX_DIMS  = mplm_pkg::MAX_DIMS_DEF,
    parameter int NODE_BITS = mplm_pkg::NODE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mplm_cfg_if.sink    i_cfg,
    mplm_pkt_if.sink    i_pkt,
    mplm_res_if.source  o_res
);
    import mplm_pkg::*;

    localparam int NODE_W = (NODE_BITS < NODE_IN_W) ? NODE_BITS : NODE_IN_W;
    localparam int DIST_W = dist_width(MAX_DIMS);

    t_cfg               r_cfg;

    logic               fd_valid;
    logic               fd_ready;
    logic [FLIT_W-1:0]  fd_flits;
    logic [NODE_W-1:0]  fd_src;
    logic [NODE_W-1:0]  fd_dst;

    logic               hd_valid;
    logic               hd_ready;
    logic [FLIT_W-1:0]  hd_flits;
    logic [DIST_W-1:0]  hd_dist;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_RADIX:     r_cfg.radix               <= i_cfg.data[RADIX_W-1:0];
                CFG_NUM_DIMS:  r_cfg.num_dims            <= i_cfg.data[DIMS_W-1:0];
                CFG_FLIT_BITS: r_cfg.flit_bits           <= i_cfg.data[FB_W-1:0];
                CFG_HOP_COST:  r_cfg.hop_cost_q16        <= i_cfg.data[Q16_W-1:0];
                CFG_COEF:      r_cfg.contention_coef_q16 <= i_cfg.data[Q16_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mplm_flit_div #(
        .NODE_W (NODE_W)
    ) u_flit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_pkt.valid),
        .o_ready (i_pkt.ready),
        .i_len   (i_pkt.length_bytes),
        .i_src   (i_pkt.src_node[NODE_W-1:0]),
        .i_dst   (i_pkt.dst_node[NODE_W-1:0]),
        .o_valid (fd_valid),
        .i_ready (fd_ready),
        .o_flits (fd_flits),
        .o_src   (fd_src),
        .o_dst   (fd_dst)
    );

    mplm_hop_dist #(
        .MAX_DIMS (MAX_DIMS),
        .NODE_W   (NODE_W)
    ) u_hop_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (fd_valid),
        .o_ready (fd_ready),
        .i_flits (fd_flits),
        .i_src   (fd_src),
        .i_dst   (fd_dst),
        .o_valid (hd_valid),
        .i_ready (hd_ready),
        .o_flits (hd_flits),
        .o_dist  (hd_dist)
    );

    mplm_cost #(
        .MAX_DIMS (MAX_DIMS)
    ) u_cost (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_valid             (hd_valid),
        .o_ready             (hd_ready),
        .i_flits             (hd_flits),
        .i_dist              (hd_dist),
        .o_valid             (o_res.valid),
        .i_ready             (o_res.ready),
        .o_latency_cycles    (o_res.latency_cycles),
        .o_contention_cycles (o_res.contention_cycles),
        .o_hop_distance      (o_res.hop_distance),
        .o_flit_count        (o_res.flit_count),
        .o_flit_hops         (o_res.flit_hops)
    );

endmodule

// ===== bench/mesh_packet_latency_model_core_tb.sv =====
// ============================================================================
// mesh_packet_latency_model_core_tb
// Self-checking bench for the torus packet latency model. A predictor works
// out latency, contention, hop distance, flit count and flit-hops for every
// packet transfer. Each result transfer is checked in order against it. The
// run has a directed part on corner settings, then random phases that
// reprogram all registers while the pipeline is empty. Both sides of the
// data path stall at random.
// ============================================================================
module mesh_packet_latency_model_core_tb;
    import mplm_pkg::*;

    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_PKTS  = 1300;

    typedef struct packed {
        logic [CYC_W-1:0]    latency_cycles;
        logic [CYC_W-1:0]    contention_cycles;
        logic [HOPD_W-1:0]   hop_distance;
        logic [FLIT_W-1:0]   flit_count;
        logic [FH_OUT_W-1:0] flit_hops;
    } t_packet_cost;

    class cost_scoreboard;
        t_cfg         regs;
        t_packet_cost pending_costs[$];
        int unsigned  mismatches;

        function new();
            regs       = CFG_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_RADIX:     regs.radix = value[RADIX_W-1:0];
                CFG_NUM_DIMS:  regs.num_dims = value[DIMS_W-1:0];
                CFG_FLIT_BITS: regs.flit_bits = value[FB_W-1:0];
                CFG_HOP_COST:  regs.hop_cost_q16 = value[Q16_W-1:0];
                CFG_COEF:      regs.contention_coef_q16 = value[Q16_W-1:0];
                default: ;
            endcase
        endfunction

        function t_packet_cost predict_cost(logic [LEN_W-1:0] len,
                                            logic [NODE_IN_W-1:0] src,
                                            logic [NODE_IN_W-1:0] dst);
            t_packet_cost    c;
            longint unsigned per_flit, flits, hops, r;
            longint unsigned s_rem, d_rem, s_dig, d_dig, usage;
            logic [127:0]    queueing, inner, scaled;
            int              dims;
            per_flit = (regs.flit_bits == '0) ? 64'd1 : 64'(regs.flit_bits);
            flits    = 64'(len);
            flits    = (flits * 8 + per_flit - 1) / per_flit;
            dims     = (int'(regs.num_dims) > MAX_DIMS_DEF) ? MAX_DIMS_DEF
                                                            : int'(regs.num_dims);
            hops     = 0;
            s_rem    = 64'(src);
            d_rem    = 64'(dst);
            // one base-radix digit per dimension, ring wraps when source digit is larger
            if (regs.radix >= 2) begin
                r = 64'(regs.radix);
                for (int i = 0; i < dims; i++) begin
                    s_dig = s_rem % r;
                    d_dig = d_rem % r;
                    hops += (s_dig > d_dig) ? r - (s_dig - d_dig) : d_dig - s_dig;
                    s_rem /= r;
                    d_rem /= r;
                end
            end
            // Q16.16 times Q16.16: 32 fraction bits after the hop cost multiply
            queueing = 128'(hops) * 128'(regs.contention_coef_q16) * 128'(flits);
            inner    = (128'(hops) << Q16_FRAC) + queueing + (128'(flits) << Q16_FRAC);
            scaled   = (inner * 128'(regs.hop_cost_q16) + 128'hFFFF_FFFF) >> 32;
            c.latency_cycles = (scaled > 128'hFFFF_FFFF) ? '1 : scaled[CYC_W-1:0];
            scaled   = (queueing * 128'(regs.hop_cost_q16)) >> 32;
            c.contention_cycles = (scaled > 128'hFFFF_FFFF) ? '1 : scaled[CYC_W-1:0];
            c.hop_distance = (hops > 64'(HOPD_MAX)) ? HOPD_W'(HOPD_MAX) : hops[HOPD_W-1:0];
            c.flit_count   = flits[FLIT_W-1:0];
            usage          = flits * (hops + flits);
            c.flit_hops    = (usage > 64'hFF_FFFF_FFFF) ? '1 : usage[FH_OUT_W-1:0];
            return c;
        endfunction

        function void note_packet(logic [LEN_W-1:0] len, logic [NODE_IN_W-1:0] src,
                                  logic [NODE_IN_W-1:0] dst);
            pending_costs.push_back(predict_cost(len, src, dst));
        endfunction

        function void compare_field(string name, logic [FH_OUT_W-1:0] want,
                                    logic [FH_OUT_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_packet_cost got);
            t_packet_cost want;
            if (pending_costs.size() == 0) begin
                $error("result transfer with no packet outstanding");
                mismatches++;
                return;
            end
            want = pending_costs.pop_front();
            compare_field("latency_cycles", FH_OUT_W'(want.latency_cycles),
                          FH_OUT_W'(got.latency_cycles));
            compare_field("contention_cycles", FH_OUT_W'(want.contention_cycles),
                          FH_OUT_W'(got.contention_cycles));
            compare_field("hop_distance", FH_OUT_W'(want.hop_distance),
                          FH_OUT_W'(got.hop_distance));
            compare_field("flit_count", FH_OUT_W'(want.flit_count),
                          FH_OUT_W'(got.flit_count));
            compare_field("flit_hops", want.flit_hops, got.flit_hops);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mplm_cfg_if cfg_if();
    mplm_pkt_if pkt_if();
    mplm_res_if res_if();

    mesh_packet_latency_model_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pkt   (pkt_if),
        .o_res   (res_if)
    );

    cost_scoreboard sb = new();
    int unsigned    send_calm = 0;
    int unsigned    recv_calm = 0;
    int unsigned    packets_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // mostly short gaps, a few long ones, now and then a calm stretch with none
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] radix, input logic [CFG_DATA_W-1:0] dims,
                              input logic [CFG_DATA_W-1:0] fb, input logic [CFG_DATA_W-1:0] hop,
                              input logic [CFG_DATA_W-1:0] coef);
        write_reg(CFG_RADIX, radix);
        write_reg(CFG_NUM_DIMS, dims);
        write_reg(CFG_FLIT_BITS, fb);
        write_reg(CFG_HOP_COST, hop);
        write_reg(CFG_COEF, coef);
    endtask

    task automatic send_packet(input logic [LEN_W-1:0] len, input logic [NODE_IN_W-1:0] src,
                               input logic [NODE_IN_W-1:0] dst);
        int unsigned gap;
        gap = pick_gap(send_calm);
        if (gap != 0) begin
            @(negedge i_clk);
            pkt_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pkt_if.valid        <= 1'b1;
        pkt_if.length_bytes <= len;
        pkt_if.src_node     <= src;
        pkt_if.dst_node     <= dst;
        do @(posedge i_clk); while (pkt_if.ready !== 1'b1);
        sb.note_packet(len, src, dst);
        packets_sent++;
    endtask

    // stop sending and let the pipeline empty out
    task automatic hold_until_drained();
        @(negedge i_clk);
        pkt_if.valid <= 1'b0;
        while (sb.pending_costs.size() != 0) @(posedge i_clk);
    endtask

    task automatic randomize_config();
        logic [CFG_DATA_W-1:0] radix, dims, fb, hop, coef;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: radix = $urandom_range(2, 8);
            5, 6, 7:       radix = $urandom_range(9, 256);
            8: begin
                case ($urandom_range(0, 4))
                    0:       radix = 0;
                    1:       radix = 1;
                    2:       radix = 2;
                    3:       radix = 256;
                    default: radix = 511;
                endcase
            end
            default: radix = $urandom_range(0, 511);
        endcase
        dims = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
        case ($urandom_range(0, 7))
            0, 1, 2, 3: fb = 1 << $urandom_range(0, 9);
            4, 5, 6:    fb = $urandom_range(1, 1023);
            default:    fb = ($urandom_range(0, 1) == 0) ? 0 : 1023;
        endcase
        case ($urandom_range(0, 5))
            0, 1:    hop = 32'h0001_0000;
            2:       hop = $urandom_range(0, 1 << 20);
            3:       hop = $urandom;
            4:       hop = ($urandom_range(0, 1) == 0) ? 0 : 32'hFFFF_FFFF;
            default: hop = $urandom_range(1 << 15, 1 << 18);
        endcase
        case ($urandom_range(0, 5))
            0, 1:    coef = 0;
            2:       coef = $urandom_range(0, 4095);
            3:       coef = $urandom_range(0, 1 << 17);
            4:       coef = $urandom;
            default: coef = 32'hFFFF_FFFF;
        endcase
        set_config(radix, dims, fb, hop, coef);
    endtask

    task automatic send_random_packet();
        longint unsigned           span;
        logic [LEN_W-1:0]          len;
        logic [NODE_IN_W-1:0]      src, dst;
        int unsigned               roll;
        // node numbers that stay inside the digits in use hit the ring math hardest
        span = 1;
        if (sb.regs.radix >= 2) repeat (sb.regs.num_dims) span = span * 64'(sb.regs.radix);
        if (span > 65536) span = 65536;
        roll = $urandom_range(0, 99);
        if (roll < 40)      len = LEN_W'($urandom_range(0, 65535));
        else if (roll < 75) len = LEN_W'($urandom_range(0, 2047));
        else if (roll < 90) len = LEN_W'($urandom_range(0, 63));
        else begin
            case ($urandom_range(0, 2))
                0:       len = 0;
                1:       len = 1;
                default: len = 16'hFFFF;
            endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            src = NODE_IN_W'($urandom_range(0, int'(span - 1)));
            dst = NODE_IN_W'($urandom_range(0, int'(span - 1)));
        end else if (roll < 90) begin
            src = NODE_IN_W'($urandom_range(0, 65535));
            dst = NODE_IN_W'($urandom_range(0, 65535));
        end else begin
            src = NODE_IN_W'($urandom_range(0, 65535));
            dst = src;
        end
        send_packet(len, src, dst);
    endtask

    initial begin : res_stall
        int unsigned stall;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            stall = pick_gap(recv_calm);
            if (stall != 0) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : res_monitor
        t_packet_cost got;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.latency_cycles    = res_if.latency_cycles;
            got.contention_cycles = res_if.contention_cycles;
            got.hop_distance      = res_if.hop_distance;
            got.flit_count        = res_if.flit_count;
            got.flit_hops         = res_if.flit_hops;
            sb.check_result(got);
        end
    end

    initial begin
        int unsigned phase_len;
        i_rst_n             = 1'b0;
        pkt_if.valid        = 1'b0;
        pkt_if.length_bytes = '0;
        pkt_if.src_node     = '0;
        pkt_if.dst_node     = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_RADIX;
        cfg_if.data         = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: radix 4, two dimensions, 32-bit flits, unit hop cost
        send_packet(16'd0, 16'h0000, 16'h0000);
        send_packet(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_packet(16'd100, 16'h0001, 16'h0000);
        send_packet(16'd1, 16'h0000, 16'h000F);
        send_packet(16'd64, 16'h0005, 16'h000A);
        send_packet(16'hFFFF, 16'h0000, 16'hFFFF);
        hold_until_drained();

        // radix zero, zero flit width, everything saturating
        set_config(0, 3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(16'hFFFF, 16'h1234, 16'h4321);
        send_packet(16'd0, 16'hFFFF, 16'h0000);
        hold_until_drained();

        // single-node rings
        set_config(1, 2, 8, 32'h0001_0000, 32'h0000_8000);
        send_packet(16'd33, 16'h00F0, 16'h000F);
        hold_until_drained();

        // radix above 256, widest wraps in both usable digits, one-bit flits
        set_config(511, 3, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(16'hFFFF, 16'd512, 16'd0);
        send_packet(16'd7, 16'd0, 16'd512);
        hold_until_drained();

        // no dimensions, zero hop cost
        set_config(4, 0, 512, 0, 0);
        send_packet(16'hFFFF, 16'h0003, 16'h0001);
        hold_until_drained();

        // fractional costs exercise the rounding
        set_config(3, 3, 7, 32'h0001_8000, 32'h0000_8001);
        send_packet(16'd13, 16'h0007, 16'h0015);
        send_packet(16'd10, 16'h0002, 16'h0000);
        hold_until_drained();

        packets_sent = 0;
        while (packets_sent < RANDOM_PKTS) begin
            randomize_config();
            phase_len = $urandom_range(20, 80);
            repeat (phase_len) begin
                send_random_packet();
                if ($urandom_range(0, 199) == 0) hold_until_drained();
            end
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_costs.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mplm_pkg.sv
src/mplm_if.sv
src/mplm_flit_div.sv
src/mplm_hop_dist.sv
src/mplm_cost.sv
src/mesh_packet_latency_model_core.sv
bench/mesh_packet_latency_model_core_tb.sv
